/* src/prd_pkg.sv */
// Shared constants and types for the path rectangle detector.
`default_nettype none

package prd_pkg;

  localparam int POS_W    = 40;
  localparam int CORNER_W = 24;
  localparam int COUNT_W  = 3;
  localparam int IDX_W    = 2;
  localparam int CORNERS  = 4;

  localparam logic [1:0] MODE_MOVE = 2'd0;
  localparam logic [1:0] MODE_LINE = 2'd1;

  localparam logic [COUNT_W-1:0] COUNT_LAST_CORNER = 3'd3;
  localparam logic [COUNT_W-1:0] COUNT_CLOSE       = 3'd4;
  localparam logic [COUNT_W-1:0] COUNT_MAX         = 3'd5;

  localparam logic signed [POS_W-1:0]    POS_MAX    = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0]    POS_MIN    = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [CORNER_W-1:0] CORNER_MAX = {1'b0, {(CORNER_W-1){1'b1}}};
  localparam logic signed [CORNER_W-1:0] CORNER_MIN = {1'b1, {(CORNER_W-1){1'b0}}};

  typedef logic [CORNERS-1:0][CORNER_W-1:0] corner_row_t;

  typedef struct packed {
    corner_row_t                 cx;
    corner_row_t                 cy;
    logic signed [CORNER_W-1:0]  low_x;
    logic signed [CORNER_W-1:0]  low_y;
    logic signed [CORNER_W-1:0]  high_x;
    logic signed [CORNER_W-1:0]  high_y;
    logic [IDX_W-1:0]            low_idx;
    logic [IDX_W-1:0]            high_idx;
    logic                        ok;
  } snap_t;

endpackage

`default_nettype wire

/* src/prd_if.sv */
// Request and result channel interfaces of the path rectangle detector.
`default_nettype none

interface prd_item_if #(parameter int OFFSET_WIDTH = 32);
  logic                           valid;
  logic                           ready;
  logic [1:0]                     mode;
  logic signed [OFFSET_WIDTH-1:0] delta_x;
  logic signed [OFFSET_WIDTH-1:0] delta_y;
  logic                           closed_flag;
  logic                           last_part;

  modport source (output valid, mode, delta_x, delta_y, closed_flag, last_part,
                  input ready);
  modport sink   (input valid, mode, delta_x, delta_y, closed_flag, last_part,
                  output ready);
endinterface

interface prd_result_if;
  logic               valid;
  logic               ready;
  logic               rectangle_found;
  logic signed [23:0] low_corner_x;
  logic signed [23:0] low_corner_y;
  logic signed [23:0] high_corner_x;
  logic signed [23:0] high_corner_y;

  modport source (output valid, rectangle_found, low_corner_x, low_corner_y,
                  high_corner_x, high_corner_y, input ready);
  modport sink   (input valid, rectangle_found, low_corner_x, low_corner_y,
                  high_corner_x, high_corner_y, output ready);
endinterface

`default_nettype wire

/* src/path_rectangle_detector_top.sv */
// Top level of the path rectangle detector.
//
//  channel   dir  payload                                              request on
//  items     in   mode, delta_x, delta_y, closed_flag, last_part        valid & ready
//  results   out  rectangle_found, low/high_corner_x, low/high_corner_y valid & ready
//
// One path part per cycle unless stalled: input register, one tracking stage, shape
// check into the result register; a result passes the input and tracking registers
// into the result register after its last part is taken. The 40-bit saturating add
// and round in the tracking stage bound the clock period.
// Synchronous reset clears the path state and all three valid flags; corners stay.
// The whole pipe stalls only while a finished path waits on a held result.
`default_nettype none

module path_rectangle_detector_top import prd_pkg::*; #(
  parameter int FRACTION_BITS = 8,
  parameter int OFFSET_WIDTH  = 32
) (
  input  wire logic    clk,
  input  wire logic    rst,
  prd_item_if.sink     items,
  prd_result_if.source results
);

  logic                           advance;
  logic                           in_valid;
  logic [1:0]                     in_mode;
  logic signed [OFFSET_WIDTH-1:0] in_dx;
  logic signed [OFFSET_WIDTH-1:0] in_dy;
  logic                           in_closed;
  logic                           in_last;
  snap_t                          snap;
  logic                           snap_valid;

  assign advance     = !(snap_valid && results.valid && !results.ready);
  assign items.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (advance) begin
      in_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && items.valid) begin
      in_mode   <= items.mode;
      in_dx     <= OFFSET_WIDTH'(items.delta_x);
      in_dy     <= OFFSET_WIDTH'(items.delta_y);
      in_closed <= items.closed_flag;
      in_last   <= items.last_part;
    end
  end

  prd_track #(
    .FRACTION_BITS (FRACTION_BITS),
    .OFFSET_WIDTH  (OFFSET_WIDTH)
  ) u_track (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .in_valid    (in_valid),
    .mode        (in_mode),
    .delta_x     (in_dx),
    .delta_y     (in_dy),
    .closed_flag (in_closed),
    .last_part   (in_last),
    .snap        (snap),
    .snap_valid  (snap_valid)
  );

  prd_check u_check (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .snap       (snap),
    .snap_valid (snap_valid),
    .results    (results)
  );

endmodule

`default_nettype wire

/* src/prd_track.sv */
// Per-part path tracking: running position, rounded corners, extremes, reject.
`default_nettype none

module prd_track import prd_pkg::*; #(
  parameter int FRACTION_BITS = 8,
  parameter int OFFSET_WIDTH  = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           advance,
  input  wire logic                           in_valid,
  input  wire logic [1:0]                     mode,
  input  wire logic signed [OFFSET_WIDTH-1:0] delta_x,
  input  wire logic signed [OFFSET_WIDTH-1:0] delta_y,
  input  wire logic                           closed_flag,
  input  wire logic                           last_part,
  output snap_t                               snap,
  output logic                                snap_valid
);

  localparam int SUM_W = ((OFFSET_WIDTH > POS_W) ? OFFSET_WIDTH : POS_W) + 1;
  localparam int RND_W = POS_W + 1;
  localparam logic signed [RND_W-1:0] HALF = (RND_W'(1) << FRACTION_BITS) >> 1;

  function automatic logic signed [POS_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > SUM_W'(POS_MAX)) begin
      r = POS_MAX;
    end else if (v < SUM_W'(POS_MIN)) begin
      r = POS_MIN;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  // half up, true floor, then clamp to the corner range
  function automatic logic signed [CORNER_W-1:0] round_pos(input logic signed [POS_W-1:0] v);
    logic signed [RND_W-1:0]    t;
    logic signed [RND_W-1:0]    q;
    logic signed [CORNER_W-1:0] r;
    t = RND_W'(v) + HALF;
    q = t >>> FRACTION_BITS;
    if (q > RND_W'(CORNER_MAX)) begin
      r = CORNER_MAX;
    end else if (q < RND_W'(CORNER_MIN)) begin
      r = CORNER_MIN;
    end else begin
      r = q[CORNER_W-1:0];
    end
    return r;
  endfunction

  logic signed [POS_W-1:0]    pos_x, pos_x_next;
  logic signed [POS_W-1:0]    pos_y, pos_y_next;
  logic [COUNT_W-1:0]         count, count_next;
  logic [IDX_W-1:0]           low_idx, low_idx_next;
  logic [IDX_W-1:0]           high_idx, high_idx_next;
  logic                       reject, reject_next;
  corner_row_t                cx, cx_next;
  corner_row_t                cy, cy_next;
  logic signed [CORNER_W-1:0] low_x, low_x_next, low_y, low_y_next;
  logic signed [CORNER_W-1:0] high_x, high_x_next, high_y, high_y_next;
  snap_t                      snap_next;

  logic signed [POS_W-1:0]    base_x, base_y;
  logic signed [SUM_W-1:0]    sum_x, sum_y;
  logic signed [POS_W-1:0]    new_x, new_y;
  logic signed [CORNER_W-1:0] rnd_x, rnd_y;
  logic                       active;

  assign active = advance && in_valid;
  assign base_x = (count == '0) ? '0 : pos_x;
  assign base_y = (count == '0) ? '0 : pos_y;
  assign sum_x  = SUM_W'(base_x) + SUM_W'(delta_x);
  assign sum_y  = SUM_W'(base_y) + SUM_W'(delta_y);
  assign new_x  = sat_sum(sum_x);
  assign new_y  = sat_sum(sum_y);
  assign rnd_x  = round_pos(new_x);
  assign rnd_y  = round_pos(new_y);

  always_comb begin
    pos_x_next    = pos_x;
    pos_y_next    = pos_y;
    count_next    = count;
    low_idx_next  = low_idx;
    high_idx_next = high_idx;
    reject_next   = reject;
    cx_next       = cx;
    cy_next       = cy;
    low_x_next    = low_x;
    low_y_next    = low_y;
    high_x_next   = high_x;
    high_y_next   = high_y;
    snap_next     = snap;
    if (active) begin
      if (!reject) begin
        if (count == '0) begin
          if (mode != MODE_MOVE || !closed_flag) begin
            reject_next = 1'b1;
          end else begin
            pos_x_next    = new_x;
            pos_y_next    = new_y;
            cx_next[0]    = rnd_x;
            cy_next[0]    = rnd_y;
            low_x_next    = rnd_x;
            low_y_next    = rnd_y;
            high_x_next   = rnd_x;
            high_y_next   = rnd_y;
            low_idx_next  = '0;
            high_idx_next = '0;
          end
        end else if (count <= COUNT_LAST_CORNER) begin
          if (mode != MODE_LINE) begin
            reject_next = 1'b1;
          end else begin
            pos_x_next            = new_x;
            pos_y_next            = new_y;
            cx_next[count[IDX_W-1:0]] = rnd_x;
            cy_next[count[IDX_W-1:0]] = rnd_y;
            if (rnd_x <= low_x && rnd_y <= low_y) begin
              low_x_next   = rnd_x;
              low_y_next   = rnd_y;
              low_idx_next = count[IDX_W-1:0];
            end
            if (rnd_x >= high_x && rnd_y >= high_y) begin
              high_x_next   = rnd_x;
              high_y_next   = rnd_y;
              high_idx_next = count[IDX_W-1:0];
            end
          end
        end else if (count == COUNT_CLOSE) begin
          if (mode != MODE_LINE || rnd_x != $signed(cx[0]) || rnd_y != $signed(cy[0])) begin
            reject_next = 1'b1;
          end
        end else begin
          reject_next = 1'b1;
        end
      end
      if (count < COUNT_MAX) begin
        count_next = count + 1'b1;
      end
      if (last_part) begin
        snap_next.cx       = cx_next;
        snap_next.cy       = cy_next;
        snap_next.low_x    = low_x_next;
        snap_next.low_y    = low_y_next;
        snap_next.high_x   = high_x_next;
        snap_next.high_y   = high_y_next;
        snap_next.low_idx  = low_idx_next;
        snap_next.high_idx = high_idx_next;
        snap_next.ok       = !reject_next && (count_next >= COUNT_CLOSE);
        pos_x_next    = '0;
        pos_y_next    = '0;
        count_next    = '0;
        low_idx_next  = '0;
        high_idx_next = '0;
        reject_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x      <= '0;
      pos_y      <= '0;
      count      <= '0;
      low_idx    <= '0;
      high_idx   <= '0;
      reject     <= 1'b0;
      snap_valid <= 1'b0;
    end else if (advance) begin
      pos_x      <= pos_x_next;
      pos_y      <= pos_y_next;
      count      <= count_next;
      low_idx    <= low_idx_next;
      high_idx   <= high_idx_next;
      reject     <= reject_next;
      snap_valid <= active && last_part;
    end
  end

  always_ff @(posedge clk) begin
    cx     <= cx_next;
    cy     <= cy_next;
    low_x  <= low_x_next;
    low_y  <= low_y_next;
    high_x <= high_x_next;
    high_y <= high_y_next;
    snap   <= snap_next;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= COUNT_MAX)
    else $error("part count out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(count) && $stable(reject) && $stable(snap_valid))
    else $error("path state moved during stall");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    active && last_part |=> snap_valid && count == '0 && !reject)
    else $error("last part did not close the path");

endmodule

`default_nettype wire

/* src/prd_check.sv */
// Rectangle shape check on the finished path and the result register.
`default_nettype none

module prd_check import prd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     advance,
  input  wire snap_t    snap,
  input  wire logic     snap_valid,
  prd_result_if.source  results
);

  logic [IDX_W-1:0]           opp_idx;
  logic signed [CORNER_W-1:0] xa, xb, ya, yb;
  logic                       degenerate, opposite, fit_ab, fit_ba, found;

  assign opp_idx    = snap.low_idx + IDX_W'(2);
  assign degenerate = (snap.low_idx == snap.high_idx) || (snap.low_x == snap.high_x)
                      || (snap.low_y == snap.high_y);
  assign opposite   = (snap.high_idx == opp_idx);

  // the two remaining corners have the other index parity
  assign xa = snap.low_idx[0] ? $signed(snap.cx[0]) : $signed(snap.cx[1]);
  assign ya = snap.low_idx[0] ? $signed(snap.cy[0]) : $signed(snap.cy[1]);
  assign xb = snap.low_idx[0] ? $signed(snap.cx[2]) : $signed(snap.cx[3]);
  assign yb = snap.low_idx[0] ? $signed(snap.cy[2]) : $signed(snap.cy[3]);

  assign fit_ab = (xa == snap.high_x) && (xb == snap.low_x) && (ya == snap.low_y)
                  && (yb == snap.high_y);
  assign fit_ba = (xb == snap.high_x) && (xa == snap.low_x) && (yb == snap.low_y)
                  && (ya == snap.high_y);
  assign found  = snap.ok && (degenerate || (opposite && (fit_ab || fit_ba)));

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (advance && snap_valid) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && snap_valid) begin
      results.rectangle_found <= found;
      results.low_corner_x    <= found ? snap.low_x  : '0;
      results.low_corner_y    <= found ? snap.low_y  : '0;
      results.high_corner_x   <= found ? snap.high_x : '0;
      results.high_corner_y   <= found ? snap.high_y : '0;
    end
  end

  a_empty_when_missing: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.rectangle_found |->
      results.low_corner_x == '0 && results.low_corner_y == '0 &&
      results.high_corner_x == '0 && results.high_corner_y == '0)
    else $error("corners not cleared on a rejected path");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |=>
      results.valid && $stable(results.rectangle_found) &&
      $stable(results.low_corner_x) && $stable(results.low_corner_y) &&
      $stable(results.high_corner_x) && $stable(results.high_corner_y))
    else $error("result changed while held");

  a_low_below_high: assert property (@(posedge clk) disable iff (rst)
    results.valid |->
      results.low_corner_x <= results.high_corner_x &&
      results.low_corner_y <= results.high_corner_y)
    else $error("low corner above high corner");

endmodule

`default_nettype wire

/* tb/tb_path_rectangle_detector_top.sv */
// Self-checking testbench for the path rectangle detector: directed and random paths.
module tb_path_rectangle_detector_top;
  import prd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 8;
  localparam longint FRAC_HALF = (FRAC > 0) ? (longint'(1) << (FRAC - 1)) : 0;
  localparam longint UNIT = longint'(1) << FRAC;
  localparam logic [1:0] MODE_CURVE  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int PART_TARGET = 1600;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic               closed;
    logic               last;
  } part_t;

  typedef struct packed {
    logic                       found;
    logic signed [CORNER_W-1:0] lo_x;
    logic signed [CORNER_W-1:0] lo_y;
    logic signed [CORNER_W-1:0] hi_x;
    logic signed [CORNER_W-1:0] hi_y;
  } rect_t;

  class rect_scoreboard;
    longint                     pos_x, pos_y;
    logic signed [CORNER_W-1:0] cor_x[CORNERS];
    logic signed [CORNER_W-1:0] cor_y[CORNERS];
    int unsigned                part_no;
    bit [IDX_W-1:0]             lo_i, hi_i;
    bit                         dropped;
    rect_t                      pending_rects[$];
    int                         mismatches;

    function new();
      mismatches = 0;
      foreach (cor_x[i]) begin
        cor_x[i] = '0;
        cor_y[i] = '0;
      end
      clear_path();
    endfunction

    function void clear_path();
      pos_x = 0;
      pos_y = 0;
      part_no = 0;
      lo_i = '0;
      hi_i = '0;
      dropped = 1'b0;
    endfunction

    function longint sat_pos(longint v);
      if (v > longint'(POS_MAX)) return longint'(POS_MAX);
      if (v < longint'(POS_MIN)) return longint'(POS_MIN);
      return v;
    endfunction

    function logic signed [CORNER_W-1:0] round_corner(longint v);
      longint q;
      q = (v + FRAC_HALF) >>> FRAC;
      if (q > longint'(CORNER_MAX)) q = longint'(CORNER_MAX);
      else if (q < longint'(CORNER_MIN)) q = longint'(CORNER_MIN);
      return q[CORNER_W-1:0];
    endfunction

    function bit is_rectangle();
      bit [IDX_W-1:0] i, j, a, b, t, opp;
      i = lo_i;
      j = hi_i;
      if (i == j || cor_x[i] == cor_x[j] || cor_y[i] == cor_y[j]) return 1'b1;
      opp = i + 2'd2;
      if (j != opp) return 1'b0;
      a = i + 2'd1;
      b = j + 2'd1;
      if (cor_x[a] == cor_x[i]) begin
        t = a;
        a = b;
        b = t;
      end
      return cor_x[a] == cor_x[j] && cor_x[b] == cor_x[i] &&
             cor_y[a] == cor_y[i] && cor_y[b] == cor_y[j];
    endfunction

    function void note_part(part_t p);
      longint                     dx, dy;
      logic signed [CORNER_W-1:0] cx, cy;
      int unsigned                k;
      rect_t                      r;
      dx = p.dx;
      dy = p.dy;
      k = part_no;
      if (!dropped) begin
        if (k == 0) begin
          if (p.mode != MODE_MOVE || !p.closed) begin
            dropped = 1'b1;
          end else begin
            pos_x = sat_pos(dx);
            pos_y = sat_pos(dy);
            cor_x[0] = round_corner(pos_x);
            cor_y[0] = round_corner(pos_y);
            lo_i = '0;
            hi_i = '0;
          end
        end else if (k <= COUNT_LAST_CORNER) begin
          if (p.mode != MODE_LINE) begin
            dropped = 1'b1;
          end else begin
            pos_x = sat_pos(pos_x + dx);
            pos_y = sat_pos(pos_y + dy);
            cx = round_corner(pos_x);
            cy = round_corner(pos_y);
            cor_x[k] = cx;
            cor_y[k] = cy;
            if (cx <= cor_x[lo_i] && cy <= cor_y[lo_i]) lo_i = k[1:0];
            if (cx >= cor_x[hi_i] && cy >= cor_y[hi_i]) hi_i = k[1:0];
          end
        end else if (k == COUNT_CLOSE) begin
          if (p.mode != MODE_LINE ||
              round_corner(sat_pos(pos_x + dx)) != cor_x[0] ||
              round_corner(sat_pos(pos_y + dy)) != cor_y[0])
            dropped = 1'b1;
        end else begin
          dropped = 1'b1;
        end
      end
      if (k < COUNT_MAX) part_no = k + 1;
      if (p.last) begin
        r = '0;
        if (!dropped && part_no >= 4 && is_rectangle()) begin
          r.found = 1'b1;
          r.lo_x = cor_x[lo_i];
          r.lo_y = cor_y[lo_i];
          r.hi_x = cor_x[hi_i];
          r.hi_y = cor_y[hi_i];
        end
        pending_rects.push_back(r);
        clear_path();
      end
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 50) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_result(rect_t got);
      rect_t want;
      if (pending_rects.size() == 0) begin
        report($sformatf("result with no path pending, found=%0b", got.found));
        return;
      end
      want = pending_rects.pop_front();
      if (got.found !== want.found)
        report($sformatf("rectangle_found got %0b want %0b", got.found, want.found));
      if (got.lo_x !== want.lo_x)
        report($sformatf("low_corner_x got %0d want %0d", got.lo_x, want.lo_x));
      if (got.lo_y !== want.lo_y)
        report($sformatf("low_corner_y got %0d want %0d", got.lo_y, want.lo_y));
      if (got.hi_x !== want.hi_x)
        report($sformatf("high_corner_x got %0d want %0d", got.hi_x, want.hi_x));
      if (got.hi_y !== want.hi_y)
        report($sformatf("high_corner_y got %0d want %0d", got.hi_y, want.hi_y));
    endtask
  endclass

  logic clk;
  logic rst;

  prd_item_if #(.OFFSET_WIDTH(32)) items ();
  prd_result_if results ();

  path_rectangle_detector_top #(
    .FRACTION_BITS(FRAC),
    .OFFSET_WIDTH (32)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .results(results)
  );

  rect_scoreboard sb;
  part_t          path_q[$];
  int             burst_left = 0;
  int             parts_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int srand(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic longint fixp(longint c);
    return c * UNIT + longint'($urandom_range(0, 255)) - 128;
  endfunction

  function automatic void add_part(logic [1:0] mode, longint dx, longint dy,
                                   logic closed, logic last);
    part_t p;
    p.mode = mode;
    p.dx = dx[31:0];
    p.dy = dy[31:0];
    p.closed = closed;
    p.last = last;
    path_q.push_back(p);
  endfunction

  // close_kind: 0 four parts, 1 fifth part back to start, 2 fifth part off by one
  function automatic void build_poly(longint ix[4], longint iy[4], int close_kind);
    longint px[5], py[5];
    longint lx, ly;
    int     n;
    for (int i = 0; i < 4; i++) begin
      px[i] = fixp(ix[i]);
      py[i] = fixp(iy[i]);
    end
    px[4] = fixp(ix[0]);
    py[4] = fixp(iy[0]);
    if (close_kind == 2) begin
      if ($urandom_range(0, 1)) px[4] += ($urandom_range(0, 1) ? UNIT : -UNIT);
      else py[4] += ($urandom_range(0, 1) ? UNIT : -UNIT);
    end
    n = (close_kind != 0) ? 5 : 4;
    lx = 0;
    ly = 0;
    for (int i = 0; i < n; i++) begin
      add_part((i == 0) ? MODE_MOVE : MODE_LINE, px[i] - lx, py[i] - ly,
               (i == 0) ? 1'b1 : 1'($urandom_range(0, 1)), i == n - 1);
      lx = px[i];
      ly = py[i];
    end
  endfunction

  function automatic void build_rect(longint x0, longint y0, longint w, longint h,
                                     bit vert, int close_kind);
    longint ix[4], iy[4];
    ix = '{x0, vert ? x0 : x0 + w, x0 + w, vert ? x0 + w : x0};
    iy = '{y0, vert ? y0 + h : y0, y0 + h, vert ? y0 : y0 + h};
    build_poly(ix, iy, close_kind);
  endfunction

  task automatic send_part(part_t p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        items.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 12);
    end
    items.valid       <= 1'b1;
    items.mode        <= p.mode;
    items.delta_x     <= p.dx;
    items.delta_y     <= p.dy;
    items.closed_flag <= p.closed;
    items.last_part   <= p.last;
    do @(posedge clk); while (!items.ready);
    sb.note_part(p);
    burst_left--;
    parts_sent++;
  endtask

  task automatic send_path();
    foreach (path_q[i]) send_part(path_q[i]);
    path_q.delete();
  endtask

  task automatic random_path();
    int     kind, span, n, idx;
    longint ix[4], iy[4];
    logic [1:0] bad_modes[3];
    bad_modes = '{MODE_MOVE, MODE_CURVE, MODE_UNUSED};
    kind = $urandom_range(0, 99);
    span = ($urandom_range(0, 9) == 0) ? (1 << 21) : 1000;
    if (kind < 45) begin
      n = $urandom_range(0, 99);
      build_rect(srand(span), srand(span), srand(span), srand(span),
                 1'($urandom_range(0, 1)), (n < 40) ? 0 : (n < 85) ? 1 : 2);
    end else if (kind < 55) begin
      n = $urandom_range(0, 2);
      build_rect(srand(span), srand(span), (n == 1) ? 0 : srand(span),
                 (n == 2) ? 0 : srand(span), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 1));
    end else if (kind < 65) begin
      foreach (ix[i]) begin
        ix[i] = srand(6);
        iy[i] = srand(6);
      end
      build_poly(ix, iy, $urandom_range(0, 2));
    end else if (kind < 80) begin
      build_rect(srand(span), srand(span), srand(span), srand(span),
                 1'($urandom_range(0, 1)), $urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0: path_q[0].mode = 2'($urandom_range(1, 3));
        1: path_q[0].closed = 1'b0;
        2: begin
          n = $urandom_range(1, 3);
          while (path_q.size() > n) void'(path_q.pop_back());
          path_q[$].last = 1'b1;
        end
        3: begin
          path_q[$].last = 1'b0;
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++)
            add_part(($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : MODE_LINE,
                     srand(512), srand(512), 1'($urandom_range(0, 1)), i == n - 1);
        end
        default: begin
          idx = $urandom_range(1, path_q.size() - 1);
          path_q[idx].mode = bad_modes[$urandom_range(0, 2)];
        end
      endcase
    end else begin
      n = $urandom_range(1, 7);
      for (int i = 0; i < n; i++) begin
        if (i == 0 && $urandom_range(0, 1))
          add_part(MODE_MOVE, $urandom, $urandom, 1'b1, n == 1);
        else
          add_part(2'($urandom_range(0, 3)), $urandom, $urandom, 1'($urandom_range(0, 1)),
                   i == n - 1);
      end
    end
    send_path();
  endtask

  // result side: shifting stall pattern plus one long hold-off
  initial begin : result_sink
    int    cyc, got, hold_left, stall_kind;
    bit    held;
    rect_t r;
    cyc = 0;
    got = 0;
    hold_left = 0;
    stall_kind = 0;
    held = 1'b0;
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (results.valid && results.ready) begin
        r.found = results.rectangle_found;
        r.lo_x  = results.low_corner_x;
        r.lo_y  = results.low_corner_y;
        r.hi_x  = results.high_corner_x;
        r.hi_y  = results.high_corner_y;
        sb.check_result(r);
        got++;
      end
      cyc++;
      if (cyc % 97 == 0) stall_kind = $urandom_range(0, 3);
      if (!held && got >= 40) begin
        held = 1'b1;
        hold_left = 400;
      end
      if (rst) begin
        results.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        results.ready <= 1'b0;
      end else begin
        case (stall_kind)
          0: results.ready <= 1'b1;
          1: results.ready <= ($urandom_range(0, 3) != 0);
          2: results.ready <= ($urandom_range(0, 3) == 0);
          default: results.ready <= (cyc % 5 != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    sb = new();
    rst               <= 1'b1;
    items.valid       <= 1'b0;
    items.mode        <= MODE_MOVE;
    items.delta_x     <= '0;
    items.delta_y     <= '0;
    items.closed_flag <= 1'b0;
    items.last_part   <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    build_rect(10, 20, 30, 40, 1'b0, 0);
    send_path();
    add_part(MODE_LINE, 256, 256, 1'b1, 1'b1);
    send_path();
    add_part(MODE_MOVE, 0, 0, 1'b0, 1'b1);
    send_path();
    add_part(MODE_MOVE, 128, -128, 1'b1, 1'b0);
    add_part(MODE_LINE, 512, 0, 1'b0, 1'b1);
    send_path();
    add_part(MODE_MOVE, 0, 0, 1'b1, 1'b0);
    add_part(MODE_CURVE, 256, 256, 1'b0, 1'b1);
    send_path();
    add_part(MODE_MOVE, 0, 0, 1'b1, 1'b0);
    add_part(MODE_LINE, 768, 0, 1'b0, 1'b0);
    add_part(MODE_LINE, 0, 768, 1'b0, 1'b0);
    add_part(MODE_UNUSED, -768, 0, 1'b1, 1'b1);
    send_path();
    build_rect(-5, -7, -12, 9, 1'b1, 1);
    path_q[$].last = 1'b0;
    add_part(MODE_LINE, 0, 0, 1'b0, 1'b1);
    send_path();
    build_rect(3, 3, 0, 0, 1'b0, 0);
    send_path();
    add_part(MODE_MOVE, 32'sh7fffffff, -32'sh80000000, 1'b1, 1'b0);
    add_part(MODE_LINE, 32'sh7fffffff, -32'sh80000000, 1'b1, 1'b0);
    add_part(MODE_LINE, -32'sh80000000, 32'sh7fffffff, 1'b0, 1'b0);
    add_part(MODE_LINE, -32'sh80000000, 32'sh7fffffff, 1'b0, 1'b1);
    send_path();

    while (parts_sent < PART_TARGET) random_path();
    items.valid <= 1'b0;

    while (sb.pending_rects.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
src/prd_pkg.sv
src/prd_if.sv
src/prd_track.sv
src/prd_check.sv
src/path_rectangle_detector_top.sv
tb/tb_path_rectangle_detector_top.sv
